// ===== rtl/tcw_pkg.sv =====
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: field widths, request codes,
// special characters and default geometry.
// ----------------------------------------------------------------------------
package tcw_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF = 80;
	localparam int ROWS_DEF    = 25;

	// fixed field widths
	localparam int REQ_W       = 2;
	localparam int CHAR_W      = 8;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = CHAR_W + ATTR_W;
	localparam int COL_FIELD_W = 7;
	localparam int ROW_FIELD_W = 5;
	localparam int IN_DATA_W   = 24;
	localparam int OUT_DATA_W  = 32;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUT   = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd1;
	localparam logic [REQ_W-1:0] REQ_READ  = 2'd2;

	// character codes
	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
	localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

	// white on black
	localparam logic [ATTR_W-1:0] DEFAULT_ATTR = 8'h0F;

endpackage

// ===== rtl/tcw_ram.sv =====
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered and held while no read is issued.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/text_console_writer.sv =====
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: screen memory of character/attribute cells plus
// a cursor, with put, clear and cell-read requests.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests arrive on the s_ stream (kind on s_tuser); each transaction
//    returns exactly one result transaction on the m_ stream, in order.
//  - attr_wr_en/attr_wr_data load the attribute byte used for written and
//    blanked cells; write it only while the console is idle.
//  - Put, newline, backspace and the unused code, unless they scroll, finish
//    in the accept cycle; the result is registered and shows up in the next
//    cycle. With m_tready high such requests are taken back to back.
//  - A read is a RAM read, then a result load that waits while the result
//    register is still full.
//  - A clear walks the screen RAM one cell a cycle.
//  - A scroll (newline or wrap off the bottom row) copies each row up one
//    cell a cycle, then blanks the last row. The single read and single
//    write port of the screen RAM set this pace.
//  - Reset homes the cursor and restores the default attribute; the screen
//    RAM is not cleared and holds garbage until a clear or a write.
//  - When the receiver stalls, the result register holds and no new request
//    is taken until it drains.
// ----------------------------------------------------------------------------
module text_console_writer #(
	parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
	parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [1:0] req_type
	input  logic [tcw_pkg::REQ_W-1:0]      s_tuser,
	// [7:0] char_code, [12:8] read_row, [19:13] read_col
	input  logic [tcw_pkg::IN_DATA_W-1:0]  s_tdata,
	// result stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col, [27:23] cursor_row
	output logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata,
	// attribute register
	input  logic                           attr_wr_en,
	input  logic [tcw_pkg::ATTR_W-1:0]     attr_wr_data
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CNTW  = $clog2(CELLS + 1);
	localparam int CW    = $clog2(COLUMNS);
	localparam int RW    = $clog2(ROWS);

	localparam logic [AW-1:0]   LAST_CELL  = AW'(CELLS - 1);
	localparam logic [CNTW-1:0] END_PTR    = CNTW'(CELLS);
	localparam logic [CNTW-1:0] FIRST_SRC  = CNTW'(COLUMNS);
	localparam logic [CW-1:0]   LAST_COL   = CW'(COLUMNS - 1);
	localparam logic [RW-1:0]   LAST_ROW   = RW'(ROWS - 1);

	// one-hot sequencer
	typedef enum logic [5:0] {
		ST_IDLE   = 6'b000001,
		ST_READ   = 6'b000010,
		ST_SCROLL = 6'b000100,
		ST_BLANK  = 6'b001000,
		ST_CLEAR  = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q, state_d;

	// request fields
	logic [tcw_pkg::REQ_W-1:0]       req_type;
	logic [tcw_pkg::CHAR_W-1:0]      char_code;
	logic [tcw_pkg::ROW_FIELD_W-1:0] read_row;
	logic [tcw_pkg::COL_FIELD_W-1:0] read_col;

	assign req_type  = s_tuser;
	assign char_code = s_tdata[7:0];
	assign read_row  = s_tdata[12:8];
	assign read_col  = s_tdata[19:13];

	// cursor and attribute
	logic [CW-1:0]              col_q, col_d;
	logic [RW-1:0]              row_q, row_d;
	logic [tcw_pkg::ATTR_W-1:0] attr_q;

	// walk counters
	logic [CNTW-1:0] src_q, src_d;
	logic [AW-1:0]   dst_q, dst_d;
	logic            rd_act_q, rd_act_d;
	logic            in_range_q, in_range_d;

	// result register
	logic                       out_vld_q;
	logic [tcw_pkg::CHAR_W-1:0] out_char_q, out_char_d;
	logic [tcw_pkg::ATTR_W-1:0] out_attr_q, out_attr_d;
	logic [CW-1:0]              out_col_q, out_col_d;
	logic [RW-1:0]              out_row_q, out_row_d;
	logic                       out_load;

	// screen RAM ports
	logic                       ram_we, ram_re;
	logic [AW-1:0]              ram_waddr, ram_raddr;
	logic [tcw_pkg::CELL_W-1:0] ram_wdata, ram_rdata;

	logic                       out_free, accept;
	logic [AW-1:0]              cur_addr, req_addr;
	logic                       req_in_range;
	logic [tcw_pkg::CELL_W-1:0] blank_cell;

	assign out_free = !out_vld_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept   = s_tvalid && s_tready;

	assign blank_cell = {attr_q, tcw_pkg::CH_SPACE};
	assign cur_addr   = AW'(row_q) * AW'(COLUMNS) + AW'(col_q);
	assign req_addr   = AW'(read_row) * AW'(COLUMNS) + AW'(read_col);
	assign req_in_range = ({2'b00, read_row} < 7'(ROWS)) &&
		({1'b0, read_col} < 8'(COLUMNS));

	tcw_ram #(
		.WIDTH (tcw_pkg::CELL_W),
		.DEPTH (CELLS)
	) u_screen (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	always_comb begin
		state_d    = state_q;
		col_d      = col_q;
		row_d      = row_q;
		src_d      = src_q;
		dst_d      = dst_q;
		rd_act_d   = rd_act_q;
		in_range_d = in_range_q;
		out_load   = 1'b0;
		out_char_d = '0;
		out_attr_d = '0;
		out_col_d  = col_q;
		out_row_d  = row_q;
		ram_we     = 1'b0;
		ram_waddr  = cur_addr;
		ram_wdata  = blank_cell;
		ram_re     = 1'b0;
		ram_raddr  = req_addr;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req_type)
						tcw_pkg::REQ_PUT: begin
							if (char_code == tcw_pkg::CH_BACKSPACE) begin
								if (col_q != '0) begin
									col_d     = col_q - 1'b1;
									ram_we    = 1'b1;
									ram_waddr = cur_addr - 1'b1;
								end
							end else begin
								// ordinary character writes the cell first
								if (char_code != tcw_pkg::CH_NEWLINE) begin
									ram_we    = 1'b1;
									ram_wdata = {attr_q, char_code};
								end
								if (char_code == tcw_pkg::CH_NEWLINE || col_q == LAST_COL) begin
									col_d = '0;
									if (row_q == LAST_ROW) begin
										// scroll: copy rows 1.. up, then blank last row
										src_d    = FIRST_SRC;
										dst_d    = '0;
										rd_act_d = 1'b0;
										state_d  = ST_SCROLL;
									end else begin
										row_d = row_q + 1'b1;
									end
								end else begin
									col_d = col_q + 1'b1;
								end
							end
						end
						tcw_pkg::REQ_CLEAR: begin
							col_d   = '0;
							row_d   = '0;
							dst_d   = '0;
							state_d = ST_CLEAR;
						end
						tcw_pkg::REQ_READ: begin
							ram_re     = req_in_range;
							in_range_d = req_in_range;
							state_d    = ST_READ;
						end
						default: begin
						end
					endcase
					if (state_d == ST_IDLE) begin
						out_load  = 1'b1;
						out_col_d = col_d;
						out_row_d = row_d;
					end
				end
			end
			ST_READ: begin
				// RAM data holds until the result register frees up
				if (out_free) begin
					out_load = 1'b1;
					if (in_range_q) begin
						out_char_d = ram_rdata[tcw_pkg::CHAR_W-1:0];
						out_attr_d = ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::CHAR_W];
					end
					state_d = ST_IDLE;
				end
			end
			ST_SCROLL: begin
				// read cell src, write it COLUMNS cells lower in the next cycle
				if (rd_act_q) begin
					ram_we    = 1'b1;
					ram_waddr = dst_q;
					ram_wdata = ram_rdata;
					dst_d     = dst_q + 1'b1;
				end
				if (src_q != END_PTR) begin
					ram_re    = 1'b1;
					ram_raddr = src_q[AW-1:0];
					src_d     = src_q + 1'b1;
					rd_act_d  = 1'b1;
				end else begin
					rd_act_d = 1'b0;
					if (!rd_act_q) begin
						state_d = ST_BLANK;
					end
				end
			end
			ST_BLANK: begin
				ram_we    = 1'b1;
				ram_waddr = dst_q;
				dst_d     = dst_q + 1'b1;
				if (dst_q == LAST_CELL) begin
					state_d = ST_DONE;
				end
			end
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = dst_q;
				dst_d     = dst_q + 1'b1;
				if (dst_q == LAST_CELL) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			col_q     <= '0;
			row_q     <= '0;
			attr_q    <= tcw_pkg::DEFAULT_ATTR;
			rd_act_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			col_q    <= col_d;
			row_q    <= row_d;
			rd_act_q <= rd_act_d;
			if (attr_wr_en) begin
				attr_q <= attr_wr_data;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		src_q      <= src_d;
		dst_q      <= dst_d;
		in_range_q <= in_range_d;
		if (out_load) begin
			out_char_q <= out_char_d;
			out_attr_q <= out_attr_d;
			out_col_q  <= out_col_d;
			out_row_q  <= out_row_d;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000,
		tcw_pkg::ROW_FIELD_W'(out_row_q),
		tcw_pkg::COL_FIELD_W'(out_col_q),
		out_attr_q,
		out_char_q};

	// scroll copy never writes the cell it is reading in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && ram_re) |-> (ram_waddr != ram_raddr))
		else $error("screen RAM read/write address collision");

	// cursor stays on the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		(32'(col_q) < COLUMNS) && (32'(row_q) < ROWS))
		else $error("cursor off screen");

	// last-row blanking only follows the row copy
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BLANK) |->
		($past(state_q) == ST_SCROLL || $past(state_q) == ST_BLANK))
		else $error("blank pass entered without scroll");

	// during a scroll the cursor stays parked at column 0 of the last row
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCROLL) |-> (row_q == LAST_ROW && col_q == '0))
		else $error("scroll with cursor not parked on last row");

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for text_console_writer. Requests go in as stream transactions.
// A shadow copy of the screen, cursor and attribute predicts every result,
// and each result transaction is checked field by field against that
// prediction. A short directed sequence comes first. Then come random
// phases, one per attribute setting: text runs that wrap, newline bursts
// that scroll, backspaces, clears, cell reads and the unused request code.
// Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int COLS        = tcw_pkg::COLUMNS_DEF;
	localparam int LINES       = tcw_pkg::ROWS_DEF;
	localparam int CELLS       = COLS * LINES;
	// a scroll or clear walks every cell with nothing accepted meanwhile
	localparam int IDLE_LIMIT  = 20000;
	localparam int PHASE_ITEMS = 200;
	localparam int MAX_REPORTS = 10;
	localparam int CHAR_MAX    = (1 << tcw_pkg::CHAR_W) - 1;
	localparam int COL_MAX     = (1 << tcw_pkg::COL_FIELD_W) - 1;
	localparam int ROW_MAX     = (1 << tcw_pkg::ROW_FIELD_W) - 1;

	typedef logic [tcw_pkg::REQ_W-1:0]       kind_t;
	typedef logic [tcw_pkg::CHAR_W-1:0]      char_t;
	typedef logic [tcw_pkg::ROW_FIELD_W-1:0] row_t;
	typedef logic [tcw_pkg::COL_FIELD_W-1:0] col_t;
	typedef logic [tcw_pkg::ATTR_W-1:0]      attr_t;

	// request code with no function in the block
	localparam kind_t REQ_UNUSED = 2'd3;

	// request transaction: tuser kind on top, tdata below, lowest field last
	typedef struct packed {
		kind_t kind;
		logic [tcw_pkg::IN_DATA_W-tcw_pkg::CHAR_W-tcw_pkg::ROW_FIELD_W-
			tcw_pkg::COL_FIELD_W-1:0] pad;
		col_t  col;
		row_t  row;
		char_t ch;
	} console_req_t;

	// result transaction, lowest field last
	typedef struct packed {
		logic [tcw_pkg::OUT_DATA_W-tcw_pkg::ROW_FIELD_W-tcw_pkg::COL_FIELD_W-
			tcw_pkg::ATTR_W-tcw_pkg::CHAR_W-1:0] pad;
		row_t  cur_row;
		col_t  cur_col;
		attr_t attr;
		char_t ch;
	} console_view_t;

	logic                           clk;
	logic                           arst_n;
	logic                           s_tvalid     = 1'b0;
	logic                           s_tready;
	// [1:0] req_type
	kind_t                          s_tuser      = '0;
	// [7:0] char_code, [12:8] read_row, [19:13] read_col
	logic [tcw_pkg::IN_DATA_W-1:0]  s_tdata      = '0;
	logic                           m_tvalid;
	logic                           m_tready     = 1'b0;
	// [7:0] cell_char, [15:8] cell_attr, [22:16] cursor_col, [27:23] cursor_row
	logic [tcw_pkg::OUT_DATA_W-1:0] m_tdata;
	logic                           attr_wr_en   = 1'b0;
	attr_t                          attr_wr_data = '0;

	text_console_writer uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tuser      (s_tuser),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.attr_wr_en   (attr_wr_en),
		.attr_wr_data (attr_wr_data)
	);

	// shadow console state
	logic [tcw_pkg::CELL_W-1:0] screen_mem [CELLS];
	int                         cur_col;
	int                         cur_row;
	attr_t                      text_attr;

	console_req_t  pending_reqs [$];
	console_view_t expected_views [$];
	logic          req_fire    = 1'b0;
	int            fail_count  = 0;
	int            idle_cycles = 0;
	int            phase_items = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// cursor to column 0 of the next row; off the bottom the screen
	// moves up one row and the last row is blanked
	function automatic void next_line();
		cur_col = 0;
		cur_row++;
		if (cur_row >= LINES) begin
			for (int i = 0; i < CELLS - COLS; i++)
				screen_mem[i] = screen_mem[i + COLS];
			for (int i = CELLS - COLS; i < CELLS; i++)
				screen_mem[i] = {text_attr, tcw_pkg::CH_SPACE};
			cur_row = LINES - 1;
		end
	endfunction

	function automatic console_view_t console_apply(console_req_t r);
		console_view_t v;
		v = '0;
		case (r.kind)
			tcw_pkg::REQ_PUT: begin
				if (r.ch == tcw_pkg::CH_NEWLINE) begin
					next_line();
				end else if (r.ch == tcw_pkg::CH_BACKSPACE) begin
					// no-op at column 0
					if (cur_col > 0) begin
						cur_col--;
						screen_mem[cur_row * COLS + cur_col] = {text_attr, tcw_pkg::CH_SPACE};
					end
				end else begin
					screen_mem[cur_row * COLS + cur_col] = {text_attr, r.ch};
					cur_col++;
					if (cur_col >= COLS)
						next_line();
				end
			end
			tcw_pkg::REQ_CLEAR: begin
				for (int i = 0; i < CELLS; i++)
					screen_mem[i] = {text_attr, tcw_pkg::CH_SPACE};
				cur_col = 0;
				cur_row = 0;
			end
			tcw_pkg::REQ_READ: begin
				// out-of-range reads return zero bytes
				if (int'(r.row) < LINES && int'(r.col) < COLS)
					{v.attr, v.ch} = screen_mem[int'(r.row) * COLS + int'(r.col)];
			end
			default: ;
		endcase
		v.cur_col = col_t'(cur_col);
		v.cur_row = row_t'(cur_row);
		return v;
	endfunction

	function automatic void note_failure(string msg);
		if (fail_count < MAX_REPORTS)
			$display("[%0t] %s", $realtime, msg);
		fail_count++;
	endfunction

	// ------------------------------------------------------------------
	// request driver: bursts of random length, random gaps in between
	// ------------------------------------------------------------------
	int burst_left = 0;
	int gap_left   = 0;

	always @(negedge clk) begin
		console_req_t r;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || req_fire) begin
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (pending_reqs.size() > 0) begin
				r = pending_reqs.pop_front();
				s_tuser  <= r.kind;
				s_tdata  <= {r.pad, r.col, r.row, r.ch};
				s_tvalid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else if ($urandom_range(0, 3) == 0) begin
					// long back-to-back stretch
					burst_left = $urandom_range(40, 150);
					gap_left   = 0;
				end else begin
					burst_left = $urandom_range(0, 12);
					gap_left   = $urandom_range(1, 8);
				end
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// result receiver: rotating ready pattern, reloaded now and then
	// ------------------------------------------------------------------
	logic [15:0] ready_pattern = '1;
	int          pattern_age   = 0;

	always @(negedge clk) begin
		if (pattern_age == 0) begin
			pattern_age <= $urandom_range(16, 128);
			case ($urandom_range(0, 3))
				0:       ready_pattern <= '1;
				1:       ready_pattern <= 16'($urandom);
				default: ready_pattern <= 16'($urandom | $urandom);
			endcase
		end else begin
			pattern_age   <= pattern_age - 1;
			ready_pattern <= {ready_pattern[14:0], ready_pattern[15]};
		end
		m_tready <= ready_pattern[0];
	end

	// ------------------------------------------------------------------
	// monitor, checker and watchdog
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		console_view_t got;
		console_view_t want;
		if (arst_n) begin
			req_fire <= s_tvalid && s_tready;
			// results first: a result this edge belongs to an older request
			if (m_tvalid && m_tready) begin
				got = m_tdata;
				if (expected_views.size() == 0) begin
					note_failure($sformatf("result with no request pending: %h", m_tdata));
				end else begin
					want = expected_views.pop_front();
					if (got.ch !== want.ch || got.attr !== want.attr ||
							got.cur_col !== want.cur_col || got.cur_row !== want.cur_row)
						note_failure($sformatf({"mismatch: expected char=%h attr=%h col=%0d row=%0d,",
							" got char=%h attr=%h col=%0d row=%0d"},
							want.ch, want.attr, want.cur_col, want.cur_row,
							got.ch, got.attr, got.cur_col, got.cur_row));
				end
			end
			if (s_tvalid && s_tready)
				expected_views.push_back(console_apply({s_tuser, s_tdata}));
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || attr_wr_en) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no transaction for %0d cycles", idle_cycles);
				$display("Simulation FAILED");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	task automatic queue_request(kind_t kind, char_t ch, row_t row, col_t col);
		console_req_t r;
		r      = '0;
		r.kind = kind;
		r.ch   = ch;
		r.row  = row;
		r.col  = col;
		pending_reqs.push_back(r);
		if (kind != REQ_UNUSED)
			phase_items++;
	endtask

	// screen is fully written by now, so any in-range cell is fair game
	task automatic queue_cell_read();
		if ($urandom_range(0, 99) >= 15)
			queue_request(tcw_pkg::REQ_READ, char_t'($urandom),
				row_t'($urandom_range(0, LINES - 1)), col_t'($urandom_range(0, COLS - 1)));
		else if ($urandom_range(0, 1) == 0)
			queue_request(tcw_pkg::REQ_READ, char_t'($urandom),
				row_t'($urandom_range(LINES, ROW_MAX)), col_t'($urandom_range(0, COL_MAX)));
		else
			queue_request(tcw_pkg::REQ_READ, char_t'($urandom),
				row_t'($urandom_range(0, ROW_MAX)), col_t'($urandom_range(COLS, COL_MAX)));
	endtask

	task automatic add_chunk();
		int    pick;
		int    n;
		int    sel;
		char_t c;
		pick = $urandom_range(0, 99);
		if (pick < 40) begin
			// line of text, long runs wrap past the last column
			n = ($urandom_range(0, 2) == 0) ? $urandom_range(40, 100) : $urandom_range(1, 20);
			repeat (n) begin
				sel = $urandom_range(0, 19);
				if (sel == 0)
					c = tcw_pkg::CH_NEWLINE;
				else if (sel == 1)
					c = tcw_pkg::CH_BACKSPACE;
				else
					c = char_t'($urandom_range(0, CHAR_MAX));
				queue_request(tcw_pkg::REQ_PUT, c, row_t'($urandom), col_t'($urandom));
			end
		end else if (pick < 65) begin
			repeat ($urandom_range(1, 6)) queue_cell_read();
		end else if (pick < 75) begin
			// newline burst, scrolls once the cursor hits the bottom row
			repeat ($urandom_range(5, 30))
				queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE,
					row_t'($urandom), col_t'($urandom));
		end else if (pick < 80) begin
			queue_request(tcw_pkg::REQ_CLEAR, char_t'($urandom),
				row_t'($urandom), col_t'($urandom));
		end else if (pick < 90) begin
			// backspace run, often past column 0
			repeat ($urandom_range(1, 10))
				queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE,
					row_t'($urandom), col_t'($urandom));
		end else begin
			repeat ($urandom_range(1, 3))
				queue_request(REQ_UNUSED, char_t'($urandom),
					row_t'($urandom), col_t'($urandom));
		end
	endtask

	task automatic wait_drained();
		while (pending_reqs.size() != 0 || s_tvalid || expected_views.size() != 0)
			@(posedge clk);
	endtask

	// drive the attribute write on falling edges, clear of the sampling posedge
	task automatic load_attribute(attr_t value);
		@(negedge clk);
		attr_wr_en   <= 1'b1;
		attr_wr_data <= value;
		@(negedge clk);
		attr_wr_en   <= 1'b0;
		text_attr = value;
	endtask

	initial begin
		attr_t phase_attr [5];
		phase_attr = '{8'h00, 8'hFF, 8'($urandom), tcw_pkg::DEFAULT_ATTR, 8'($urandom)};
		arst_n    = 1'b0;
		cur_col   = 0;
		cur_row   = 0;
		text_attr = tcw_pkg::DEFAULT_ATTR;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: screen memory is garbage until the clear, so the
		// reads before it only touch the cell just written
		queue_request(tcw_pkg::REQ_PUT, 8'd65, '0, '0);
		queue_request(tcw_pkg::REQ_READ, '0, 5'd0, 7'd0);
		queue_request(REQ_UNUSED, 8'hFF, '1, '1);
		queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, '0, '0);   // blanks (0,0)
		queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, '1, '1);   // at column 0: no-op
		queue_request(tcw_pkg::REQ_READ, '1, 5'd0, 7'd0);
		queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, '0, '0);
		queue_request(tcw_pkg::REQ_CLEAR, '1, '1, '1);
		queue_request(tcw_pkg::REQ_READ, '0, 5'(LINES - 1), 7'(COLS - 1));
		queue_request(tcw_pkg::REQ_READ, '0, '1, '1);            // row and column out of range
		queue_request(tcw_pkg::REQ_READ, '0, 5'd0, 7'(COLS));    // column out of range
		queue_request(tcw_pkg::REQ_READ, '0, 5'(LINES), 7'd0);   // row out of range
		queue_request(tcw_pkg::REQ_PUT, 8'hFF, '0, '0);
		queue_request(tcw_pkg::REQ_PUT, 8'h00, '1, '1);
		queue_request(tcw_pkg::REQ_PUT, 8'h80, '0, '0);
		queue_request(tcw_pkg::REQ_READ, '0, 5'd0, 7'd0);
		queue_request(tcw_pkg::REQ_READ, '0, 5'd0, 7'd1);
		queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_NEWLINE, '0, '0);
		queue_request(tcw_pkg::REQ_PUT, tcw_pkg::CH_BACKSPACE, '0, '0);
		queue_request(tcw_pkg::REQ_PUT, 8'h5A, '0, '0);
		queue_request(REQ_UNUSED, 8'h00, '0, '0);
		queue_request(tcw_pkg::REQ_READ, '0, 5'd1, 7'd0);
		wait_drained();

		// random phases, one attribute setting each
		foreach (phase_attr[p]) begin
			load_attribute(phase_attr[p]);
			phase_items = 0;
			while (phase_items < PHASE_ITEMS)
				add_chunk();
			wait_drained();
		end

		// let any stray result show up
		repeat (20) @(posedge clk);
		if (expected_views.size() != 0)
			note_failure($sformatf("%0d results never arrived", expected_views.size()));
		if (fail_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
